// ----- rtl/mhpq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared widths, status codes, datapath commands and the datapath status
// bundle for the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int IdFieldW = 16;
  localparam int CostW    = 32;
  localparam int StatusW  = 2;
  localparam int TotalW   = 7;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_FOUND,
    OP_APPEND,
    OP_FULL,
    OP_EMPTY,
    OP_POP_RD1,
    OP_POP_RDL,
    OP_POP_KEY,
    OP_UP_RD,
    OP_UP_MOVE,
    OP_DN_RDL,
    OP_DN_RDR,
    OP_DN_MOVE,
    OP_PLACE,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic is_pop;
    logic count_zero;
    logic full;
    logic match;
    logic scan_end;
    logic raised;
    logic at_root;
    logic has_left;
    logic parent_less;
    logic child_less;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/mhpq_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_in_if
// Request channel: operation, item id and cost with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhpq_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     action;
  logic        [mhpq_pkg::IdFieldW-1:0]     item_id;
  logic signed [mhpq_pkg::CostW-1:0]        cost;

  modport source (output valid, action, item_id, cost, input ready);
  modport sink   (input valid, action, item_id, cost, output ready);
endinterface
`default_nettype wire

// ----- rtl/mhpq_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_out_if
// Result channel: popped id, status and entry count with a valid/ready
// handshake.
// ----------------------------------------------------------------------------
interface mhpq_out_if;
  logic                                valid;
  logic                                ready;
  logic [mhpq_pkg::IdFieldW-1:0]       popped_item;
  logic [mhpq_pkg::StatusW-1:0]        status;
  logic [mhpq_pkg::TotalW-1:0]         entry_total;

  modport source (output valid, popped_item, status, entry_total, input ready);
  modport sink   (input valid, popped_item, status, entry_total, output ready);
endinterface
`default_nettype wire

// ----- rtl/mhpq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/mhpq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for search, insert, pop and sift operations. It drives one
// datapath command per cycle and owns both channel handshakes.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire mhpq_pkg::dp_status_t st_i,
  output mhpq_pkg::dp_op_e          op_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_START = 12'b0000_0000_0010,
    S_SRCH  = 12'b0000_0000_0100,
    S_INS   = 12'b0000_0000_1000,
    S_POPL  = 12'b0000_0001_0000,
    S_POPK  = 12'b0000_0010_0000,
    S_UPRD  = 12'b0000_0100_0000,
    S_UPCMP = 12'b0000_1000_0000,
    S_DNRDL = 12'b0001_0000_0000,
    S_DNRDR = 12'b0010_0000_0000,
    S_DNCMP = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   emit;

  always_comb begin
    state_d = state_q;
    op_o    = mhpq_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = mhpq_pkg::OP_LOAD;
          state_d = S_START;
        end
      end
      S_START: begin
        if (st_i.is_pop) begin
          if (st_i.count_zero) begin
            op_o    = mhpq_pkg::OP_EMPTY;
            state_d = S_FIN;
          end else begin
            op_o    = mhpq_pkg::OP_POP_RD1;
            state_d = S_POPL;
          end
        end else if (st_i.count_zero) begin
          state_d = S_INS;
        end else begin
          op_o    = mhpq_pkg::OP_SCAN;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (st_i.match) begin
          op_o    = mhpq_pkg::OP_FOUND;
          state_d = st_i.raised ? S_DNRDL : S_UPRD;
        end else if (st_i.scan_end) begin
          state_d = S_INS;
        end else begin
          op_o = mhpq_pkg::OP_SCAN;
        end
      end
      S_INS: begin
        if (st_i.full) begin
          op_o    = mhpq_pkg::OP_FULL;
          state_d = S_FIN;
        end else begin
          op_o    = mhpq_pkg::OP_APPEND;
          state_d = S_UPRD;
        end
      end
      S_POPL: begin
        op_o    = mhpq_pkg::OP_POP_RDL;
        state_d = S_POPK;
      end
      S_POPK: begin
        op_o    = mhpq_pkg::OP_POP_KEY;
        state_d = S_DNRDL;
      end
      S_UPRD: begin
        if (st_i.at_root) begin
          op_o    = mhpq_pkg::OP_PLACE;
          state_d = S_FIN;
        end else begin
          op_o    = mhpq_pkg::OP_UP_RD;
          state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (st_i.parent_less) begin
          op_o    = mhpq_pkg::OP_UP_MOVE;
          state_d = S_UPRD;
        end else begin
          op_o    = mhpq_pkg::OP_PLACE;
          state_d = S_FIN;
        end
      end
      S_DNRDL: begin
        if (st_i.has_left) begin
          op_o    = mhpq_pkg::OP_DN_RDL;
          state_d = S_DNRDR;
        end else begin
          op_o    = mhpq_pkg::OP_PLACE;
          state_d = S_FIN;
        end
      end
      S_DNRDR: begin
        op_o    = mhpq_pkg::OP_DN_RDR;
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        if (st_i.child_less) begin
          op_o    = mhpq_pkg::OP_DN_MOVE;
          state_d = S_DNRDL;
        end else begin
          op_o    = mhpq_pkg::OP_PLACE;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          op_o    = mhpq_pkg::OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign emit        = (op_o == mhpq_pkg::OP_EMIT);
  assign out_valid_d = emit | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/mhpq_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_datapath
// Heap storage, fill count, search and sift registers, comparators and the
// result register. Executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
module mhpq_datapath #(
  parameter int CAPACITY = 64,
  parameter int ID_BITS  = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_action_i,
  input  wire logic        [mhpq_pkg::IdFieldW-1:0] in_item_id_i,
  input  wire logic signed [mhpq_pkg::CostW-1:0]    in_cost_i,
  input  wire mhpq_pkg::dp_op_e                     op_i,
  output mhpq_pkg::dp_status_t                      status_o,
  output logic             [mhpq_pkg::IdFieldW-1:0] popped_item_o,
  output logic             [mhpq_pkg::StatusW-1:0]  status_code_o,
  output logic             [mhpq_pkg::TotalW-1:0]   entry_total_o
);

  localparam int IdW   = (ID_BITS < mhpq_pkg::IdFieldW) ? ID_BITS : mhpq_pkg::IdFieldW;
  localparam int CostW = mhpq_pkg::CostW;
  localparam int EntW  = IdW + CostW;
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int AddrW = $clog2(CAPACITY);

  logic                        key_pop_q;
  logic        [IdW-1:0]       key_id_q;
  logic signed [CostW-1:0]     key_cost_q;
  logic        [CntW-1:0]      count_q;
  logic        [CntW-1:0]      pos_q;
  logic        [CntW-1:0]      scan_q;
  logic        [CntW-1:0]      prev_q;
  logic                        pend_q;
  logic                        last_q;
  logic        [EntW-1:0]      child_q;
  logic        [CntW-1:0]      child_pos_q;
  logic                        rvld_q;
  logic        [IdW-1:0]       popped_q;
  mhpq_pkg::status_e           res_status_q;
  logic        [IdW-1:0]       out_pop_q;
  mhpq_pkg::status_e           out_status_q;
  logic        [mhpq_pkg::TotalW-1:0] out_total_q;

  logic                        ram_we;
  logic        [AddrW-1:0]     ram_waddr;
  logic        [EntW-1:0]      ram_wdata;
  logic                        ram_re;
  logic        [AddrW-1:0]     ram_raddr;
  logic        [EntW-1:0]      rdata;

  logic        [IdW-1:0]       rd_id;
  logic signed [CostW-1:0]     rd_cost;
  logic signed [CostW-1:0]     child_cost;
  logic        [EntW-1:0]      key_ent;
  logic        [CntW:0]        left;
  logic        [CntW:0]        right;
  logic        [CntW:0]        cnt_ext;
  logic        [CntW-1:0]      parent;
  logic                        has_left;
  logic                        has_right;
  logic                        right_take;
  logic        [EntW-1:0]      sel_ent;
  logic signed [CostW-1:0]     sel_cost;
  logic        [CntW-1:0]      sel_pos;

  function automatic logic [AddrW-1:0] to_addr(input logic [CntW-1:0] p);
    to_addr = AddrW'(p - CntW'(1));
  endfunction

  assign rd_id      = rdata[EntW-1:CostW];
  assign rd_cost    = $signed(rdata[CostW-1:0]);
  assign child_cost = $signed(child_q[CostW-1:0]);
  assign key_ent    = {key_id_q, key_cost_q};
  assign left       = {pos_q, 1'b0};
  assign right      = {pos_q, 1'b1};
  assign cnt_ext    = {1'b0, count_q};
  assign parent     = pos_q >> 1;
  assign has_left   = (left <= cnt_ext);
  assign has_right  = (right <= cnt_ext);

  assign right_take = rvld_q && (rd_cost < child_cost);
  assign sel_ent    = right_take ? rdata : child_q;
  assign sel_cost   = $signed(sel_ent[CostW-1:0]);
  assign sel_pos    = right_take ? {child_pos_q[CntW-1:1], 1'b1} : child_pos_q;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (op_i)
      mhpq_pkg::OP_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = to_addr(scan_q);
      end
      mhpq_pkg::OP_POP_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = to_addr(CntW'(1));
      end
      mhpq_pkg::OP_POP_RDL: begin
        ram_re    = 1'b1;
        ram_raddr = to_addr(count_q);
      end
      mhpq_pkg::OP_UP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = to_addr(parent);
      end
      mhpq_pkg::OP_DN_RDL: begin
        ram_re    = 1'b1;
        ram_raddr = to_addr(CntW'(left));
      end
      mhpq_pkg::OP_DN_RDR: begin
        ram_re    = has_right;
        ram_raddr = to_addr(CntW'(right));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = to_addr(pos_q);
    ram_wdata = key_ent;
    unique case (op_i)
      mhpq_pkg::OP_UP_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = rdata;
      end
      mhpq_pkg::OP_DN_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = sel_ent;
      end
      mhpq_pkg::OP_PLACE: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  mhpq_ram #(
    .Width (EntW),
    .Depth (CAPACITY)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      unique case (op_i)
        mhpq_pkg::OP_LOAD:    pend_q  <= 1'b0;
        mhpq_pkg::OP_SCAN:    pend_q  <= 1'b1;
        mhpq_pkg::OP_APPEND:  count_q <= count_q + CntW'(1);
        mhpq_pkg::OP_POP_KEY: count_q <= count_q - CntW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      mhpq_pkg::OP_LOAD: begin
        key_pop_q    <= in_action_i;
        key_id_q     <= IdW'(in_item_id_i);
        key_cost_q   <= in_cost_i;
        scan_q       <= CntW'(1);
        popped_q     <= '0;
        res_status_q <= mhpq_pkg::STATUS_OK;
      end
      mhpq_pkg::OP_SCAN: begin
        prev_q <= scan_q;
        last_q <= (scan_q == count_q);
        scan_q <= scan_q + CntW'(1);
      end
      mhpq_pkg::OP_FOUND:  pos_q        <= prev_q;
      mhpq_pkg::OP_APPEND: pos_q        <= count_q + CntW'(1);
      mhpq_pkg::OP_FULL:   res_status_q <= mhpq_pkg::STATUS_FULL;
      mhpq_pkg::OP_EMPTY:  res_status_q <= mhpq_pkg::STATUS_EMPTY;
      mhpq_pkg::OP_POP_RDL: popped_q    <= rd_id;
      mhpq_pkg::OP_POP_KEY: begin
        key_id_q   <= rd_id;
        key_cost_q <= rd_cost;
        pos_q      <= CntW'(1);
      end
      mhpq_pkg::OP_UP_MOVE: pos_q <= parent;
      mhpq_pkg::OP_DN_RDR: begin
        child_q     <= rdata;
        child_pos_q <= CntW'(left);
        rvld_q      <= has_right;
      end
      mhpq_pkg::OP_DN_MOVE: pos_q <= sel_pos;
      mhpq_pkg::OP_EMIT: begin
        out_pop_q    <= popped_q;
        out_status_q <= res_status_q;
        out_total_q  <= mhpq_pkg::TotalW'(count_q);
      end
      default: begin
      end
    endcase
  end

  assign status_o.is_pop      = key_pop_q;
  assign status_o.count_zero  = (count_q == '0);
  assign status_o.full        = (count_q == CntW'(CAPACITY));
  assign status_o.match       = pend_q && (rd_id == key_id_q);
  assign status_o.scan_end    = pend_q && last_q;
  assign status_o.raised      = (rd_cost < key_cost_q);
  assign status_o.at_root     = (pos_q == CntW'(1));
  assign status_o.has_left    = has_left;
  assign status_o.parent_less = (key_cost_q < rd_cost);
  assign status_o.child_less  = (sel_cost < key_cost_q);

  assign popped_item_o = mhpq_pkg::IdFieldW'(out_pop_q);
  assign status_code_o = out_status_q;
  assign entry_total_o = out_total_q;

endmodule
`default_nettype wire

// ----- rtl/min_heap_priority_queue_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// A pop on an empty heap goes straight to its result; any other request has a
// setup and then a sift. Setup reads the root and last entry for a pop, scans up to
// slot k for an update of the id in slot k and all n entries held for a new id; a
// refused insert does no sift. Sift up reads the parent and compares at each
// level below the root; sift down reads the children and compares at each level
// above a leaf. A new request is accepted once the result is issued. Reset empties it.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_core #(
  parameter int CAPACITY = 64,
  parameter int ID_BITS  = 16
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  mhpq_in_if.sink    in_i,
  mhpq_out_if.source out_o
);

  mhpq_pkg::dp_status_t dp_status;
  mhpq_pkg::dp_op_e     dp_op;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .st_i        (dp_status),
    .op_o        (dp_op)
  );

  mhpq_datapath #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_action_i   (in_i.action),
    .in_item_id_i  (in_i.item_id),
    .in_cost_i     (in_i.cost),
    .op_i          (dp_op),
    .status_o      (dp_status),
    .popped_item_o (out_o.popped_item),
    .status_code_o (out_o.status),
    .entry_total_o (out_o.entry_total)
  );

endmodule
`default_nettype wire
